FILE: rtl/core/conv3ch_sigmoid_layer_core_assert.svh
// Assertion macros for the conv3ch sigmoid layer core checker.
// Needs clk and rst_n in the scope of the including module.
`ifndef CONV3CH_SIGMOID_LAYER_CORE_ASSERT_SVH
`define CONV3CH_SIGMOID_LAYER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CONV3SIG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CONV3SIG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/conv3sig_pkg.sv
// Constants and sizes shared by the conv3ch sigmoid layer core and its testbench.
// No dependencies.
`timescale 1ns / 1ps

package conv3sig_pkg;

  localparam int FILTER_SIZE  = 3;
  localparam int MAX_IMAGE    = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int NUM_CH       = 3;
  localparam int FRAC_BITS    = 12;

  localparam int CFG_W      = 6;
  localparam int POS_W      = $clog2(MAX_IMAGE);
  localparam int FIDX_W     = $clog2(FILTER_SIZE);
  localparam int BIAS_AW    = 2 * POS_W;
  localparam int BIAS_DEPTH = MAX_IMAGE * MAX_IMAGE;
  localparam int CLR_W      = BIAS_AW + 1;
  localparam int PIX_W      = NUM_CH * SAMPLE_WIDTH;
  localparam int LB_W       = (FILTER_SIZE - 1) * PIX_W;
  localparam int PROD_W     = 2 * SAMPLE_WIDTH;
  localparam int SUM_W      = PROD_W + $clog2(FILTER_SIZE * NUM_CH) + 1;
  localparam int ACC_W      = PROD_W + $clog2(FILTER_SIZE * FILTER_SIZE * NUM_CH) + 2;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(MAX_IMAGE);

  // request kinds on in_tuser
  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_TAP   = 2'd1;
  localparam logic [1:0] REQ_BIAS  = 2'd2;

  // sigmoid datapath
  localparam int SQUARINGS = 8;
  localparam int QUO_W     = 17;
  localparam int ST_E      = 6;
  localparam int ST_DEN    = ST_E + SQUARINGS + 1;
  localparam int NSTG      = ST_DEN + QUO_W + 1;
  localparam logic [15:0] RECIP3 = 16'd43691;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

endpackage

FILE: rtl/core/conv3ch_sigmoid_layer_core.sv
// Three-channel 3x3 convolution with per-position bias and sigmoid activation.
// Depends on conv3sig_pkg.
`timescale 1ns / 1ps

// A result runs through stage 1, stage 2 and the result pipeline to the output register.
// Throughput: one word per cycle unless the output stalls, loads and pixels alike;
// the line memory read of the next column overlaps the write-back of the current one.
// Reset: after rst_n rises the bias memory is swept to zero, one entry a cycle,
// in_tready low over all 1024 entries; configuration writes are taken throughout.
module conv3ch_sigmoid_layer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_ch0, pixel_ch1, pixel_ch2, tap_channel, row_index, col_index, load_value, pad
  input  logic [conv3sig_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // activation, out_row, out_col, pad
  output logic [conv3sig_pkg::OUT_TDATA_W-1:0] out_tdata,
  // frame_last
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  localparam int FS     = conv3sig_pkg::FILTER_SIZE;
  localparam int NCH    = conv3sig_pkg::NUM_CH;
  localparam int SW     = conv3sig_pkg::SAMPLE_WIDTH;
  localparam int PW     = conv3sig_pkg::POS_W;
  localparam int PIXW   = conv3sig_pkg::PIX_W;
  localparam int NSTG   = conv3sig_pkg::NSTG;
  localparam int QW     = conv3sig_pkg::QUO_W;
  localparam int SQ     = conv3sig_pkg::SQUARINGS;
  localparam int ACC_W  = conv3sig_pkg::ACC_W;
  localparam int SUM_W  = conv3sig_pkg::SUM_W;
  localparam int PROD_W = conv3sig_pkg::PROD_W;
  localparam int FB     = conv3sig_pkg::FRAC_BITS;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [PW-1:0] orow;
    logic [PW-1:0] ocol;
    logic          last;
    logic          neg;
  } meta_t;

  // input fields
  logic [PIXW-1:0]  in_pix;
  logic [1:0]       in_tch;
  logic [PW-1:0]    in_row;
  logic [PW-1:0]    in_col;
  logic [SW-1:0]    in_val;
  logic [1:0]       in_req;

  assign in_pix = in_tdata[47:0];
  assign in_tch = in_tdata[49:48];
  assign in_row = in_tdata[54:50];
  assign in_col = in_tdata[59:55];
  assign in_val = in_tdata[75:60];
  assign in_req = in_tuser;

  logic en;
  logic in_acc;
  logic clr_done;
  logic [conv3sig_pkg::CLR_W-1:0] clr_cnt_r;

  logic [NSTG-1:0] v_r;
  logic            out_tvalid_r;

  assign en       = !(out_tvalid_r && !out_tready && v_r[NSTG-1]);
  assign clr_done = clr_cnt_r[conv3sig_pkg::CLR_W-1];
  assign in_tready = en && clr_done;
  assign in_acc   = in_tvalid && in_tready;

  // bias memory clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // image size and raster position
  logic [conv3sig_pkg::CFG_W-1:0] img_size_r;
  logic [conv3sig_pkg::CFG_W-1:0] n_eff;
  logic [PW-1:0] pix_row_r, pix_col_r;
  logic          row_end, col_end, emit_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_size_r <= conv3sig_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      img_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (img_size_r < conv3sig_pkg::CFG_W'(FS)) begin
      n_eff = conv3sig_pkg::CFG_W'(FS);
    end else if (img_size_r > conv3sig_pkg::CFG_W'(conv3sig_pkg::MAX_IMAGE)) begin
      n_eff = conv3sig_pkg::CFG_W'(conv3sig_pkg::MAX_IMAGE);
    end else begin
      n_eff = img_size_r;
    end
  end

  assign row_end = ({1'b0, pix_row_r} + 1'b1) == n_eff;
  assign col_end = ({1'b0, pix_col_r} + 1'b1) == n_eff;
  assign emit_c  = (pix_row_r >= PW'(FS - 1)) && (pix_col_r >= PW'(FS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      pix_row_r <= '0;
      pix_col_r <= '0;
    end else if (in_acc && in_req == conv3sig_pkg::REQ_PIXEL) begin
      if (col_end) begin
        pix_col_r <= '0;
        pix_row_r <= row_end ? '0 : pix_row_r + 1'b1;
      end else begin
        pix_col_r <= pix_col_r + 1'b1;
      end
    end
  end

  // stage 1: line memory read in flight
  logic            s1_v_r;
  logic [1:0]      s1_req_r;
  logic [PIXW-1:0] s1_pix_r;
  logic [PW-1:0]   s1_pcol_r;
  logic [PW-1:0]   s1_row_r, s1_col_r;
  logic [1:0]      s1_tch_r;
  logic [SW-1:0]   s1_val_r;
  logic            s1_emit_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_acc && (in_req == conv3sig_pkg::REQ_PIXEL ||
                           in_req == conv3sig_pkg::REQ_TAP ||
                           in_req == conv3sig_pkg::REQ_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req_r  <= in_req;
      s1_pix_r  <= in_pix;
      s1_pcol_r <= pix_col_r;
      s1_tch_r  <= in_tch;
      s1_val_r  <= in_val;
      s1_emit_r <= emit_c;
      s1_last_r <= row_end && col_end;
      // pixels carry their output position, loads their target index
      if (in_req == conv3sig_pkg::REQ_PIXEL) begin
        s1_row_r <= pix_row_r - PW'(FS - 1);
        s1_col_r <= pix_col_r - PW'(FS - 1);
      end else begin
        s1_row_r <= in_row;
        s1_col_r <= in_col;
      end
    end
  end

  // line memory: per column the previous FS-1 rows of samples, oldest lowest
  logic [conv3sig_pkg::LB_W-1:0] lb_mem [conv3sig_pkg::MAX_IMAGE];
  logic [conv3sig_pkg::LB_W-1:0] lb_rd_r;
  logic [conv3sig_pkg::LB_W-1:0] lb_wr;
  logic [PIXW-1:0]               colv [FS];
  logic                          s1_pix_go;

  assign s1_pix_go = en && s1_v_r && s1_req_r == conv3sig_pkg::REQ_PIXEL;

  always_comb begin
    for (int i = 0; i < FS - 1; i++) begin
      colv[i] = lb_rd_r[i*PIXW +: PIXW];
    end
    colv[FS-1] = s1_pix_r;
    for (int i = 0; i < FS - 1; i++) begin
      lb_wr[i*PIXW +: PIXW] = colv[i+1];
    end
  end

  // consecutive pixels always hit different columns, so the write-back
  // never races the next read
  always_ff @(posedge clk) begin
    if (s1_pix_go) begin
      lb_mem[s1_pcol_r] <= lb_wr;
    end
    if (en) begin
      lb_rd_r <= lb_mem[pix_col_r];
    end
  end

  // window registers, newest column at the high index
  logic [PIXW-1:0] win_r [FS][FS];

  always_ff @(posedge clk) begin
    if (s1_pix_go) begin
      for (int i = 0; i < FS; i++) begin
        for (int j = 0; j < FS - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
        win_r[i][FS-1] <= colv[i];
      end
    end
  end

  // bias memory: write from bias words, read for pixels, swept after reset
  logic [SW-1:0] bias_mem [conv3sig_pkg::BIAS_DEPTH];
  logic [SW-1:0] bias_rd_r;

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      bias_mem[clr_cnt_r[conv3sig_pkg::BIAS_AW-1:0]] <= '0;
    end else if (en && s1_v_r && s1_req_r == conv3sig_pkg::REQ_BIAS) begin
      bias_mem[{s1_row_r, s1_col_r}] <= s1_val_r;
    end
    if (en) begin
      bias_rd_r <= bias_mem[{s1_row_r, s1_col_r}];
    end
  end

  // stage 2: window ready, tap writes applied here to keep word order
  logic          s2_v_r;
  logic [1:0]    s2_req_r;
  logic [1:0]    s2_tch_r;
  logic [PW-1:0] s2_row_r, s2_col_r;
  logic [SW-1:0] s2_val_r;
  logic          s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && (s1_req_r == conv3sig_pkg::REQ_TAP ||
                (s1_req_r == conv3sig_pkg::REQ_PIXEL && s1_emit_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_req_r  <= s1_req_r;
      s2_tch_r  <= s1_tch_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_val_r  <= s1_val_r;
      s2_last_r <= s1_last_r;
    end
  end

  logic signed [SW-1:0] weight_r [NCH][FS][FS];
  logic                 tap_ok;

  assign tap_ok = s2_tch_r < 2'(NCH) && s2_row_r < PW'(FS) && s2_col_r < PW'(FS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        for (int i = 0; i < FS; i++) begin
          for (int j = 0; j < FS; j++) begin
            weight_r[c][i][j] <= '0;
          end
        end
      end
    end else if (en && s2_v_r && s2_req_r == conv3sig_pkg::REQ_TAP && tap_ok) begin
      weight_r[s2_tch_r][s2_row_r[conv3sig_pkg::FIDX_W-1:0]]
              [s2_col_r[conv3sig_pkg::FIDX_W-1:0]] <= s2_val_r;
    end
  end

  // result pipeline valids and position
  meta_t meta_r [NSTG];
  logic  neg_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], s2_v_r && s2_req_r == conv3sig_pkg::REQ_PIXEL};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0].orow <= s2_row_r;
      meta_r[0].ocol <= s2_col_r;
      meta_r[0].last <= s2_last_r;
      meta_r[0].neg  <= 1'b0;
      for (int k = 1; k < NSTG; k++) begin
        if (k != 2) begin
          meta_r[k] <= meta_r[k-1];
        end
      end
      // sign of the saturated sum joins at stage 2
      meta_r[2].orow <= meta_r[1].orow;
      meta_r[2].ocol <= meta_r[1].ocol;
      meta_r[2].last <= meta_r[1].last;
      meta_r[2].neg  <= neg_c;
    end
  end

  // products, one multiplier per tap and channel
  logic signed [PROD_W-1:0] prod_r [NCH][FS][FS];
  logic [SW-1:0]            bias_p_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        for (int i = 0; i < FS; i++) begin
          for (int j = 0; j < FS; j++) begin
            prod_r[c][i][j] <= $signed(win_r[i][j][c*SW +: SW]) * weight_r[c][i][j];
          end
        end
      end
      bias_p_r[0] <= bias_rd_r;
      bias_p_r[1] <= bias_p_r[0];
    end
  end

  // row sums
  logic signed [SUM_W-1:0] rsum_c [FS];
  logic signed [SUM_W-1:0] sum_r  [FS];

  always_comb begin
    for (int i = 0; i < FS; i++) begin
      rsum_c[i] = '0;
      for (int j = 0; j < FS; j++) begin
        for (int c = 0; c < NCH; c++) begin
          rsum_c[i] = rsum_c[i] + SUM_W'(prod_r[c][i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= rsum_c;
    end
  end

  // bias, round half up to Q4.12, saturate, magnitude
  logic signed [ACC_W-1:0] acc_c, rnd_c, sfull_c;
  logic signed [SW-1:0]    sat_c;
  logic [15:0]             mag_c;
  logic [15:0]             a_r [4];

  always_comb begin
    acc_c = ACC_W'($signed(bias_p_r[1])) <<< FB;
    for (int i = 0; i < FS; i++) begin
      acc_c = acc_c + ACC_W'(sum_r[i]);
    end
    rnd_c   = acc_c + ACC_W'(1 << (FB - 1));
    sfull_c = rnd_c >>> FB;
    priority if (sfull_c < SAT_LO) begin
      sat_c = -16'sd32768;
    end else if (sfull_c > SAT_HI) begin
      sat_c = 16'sd32767;
    end else begin
      sat_c = SW'(sfull_c);
    end
    neg_c = sat_c[SW-1];
    mag_c = neg_c ? 16'(~sat_c + 16'd1) : 16'(sat_c);
  end

  // Taylor terms of exp(-a/4096/256)
  logic [31:0] sq_c;
  logic [36:0] t3p_c;
  logic [31:0] t4p_c, d6p_c;
  logic [26:0] d24p_c;
  logic [20:0] t2_r [3];
  logic [15:0] t3_r;
  logic [10:0] t4_r;
  logic [13:0] t3d6_r;
  logic [31:0] e0_c;

  assign sq_c   = a_r[0] * a_r[0];
  assign t3p_c  = t2_r[0] * a_r[1];
  assign t4p_c  = t3_r * a_r[2];
  assign d6p_c  = t3_r * conv3sig_pkg::RECIP3;
  assign d24p_c = t4_r * conv3sig_pkg::RECIP3;
  assign e0_c   = ONE_Q30 - {6'd0, a_r[3], 10'd0} + {12'd0, t2_r[2][20:1]}
                  - {18'd0, t3d6_r} + {25'd0, d24p_c[26:20]};

  logic [30:0] e_r [SQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]  <= mag_c;
      t2_r[0] <= sq_c[30:10];
      a_r[1]  <= a_r[0];
      t3_r    <= t3p_c[35:20];
      t2_r[1] <= t2_r[0];
      a_r[2]  <= a_r[1];
      t4_r    <= t4p_c[30:20];
      t3d6_r  <= d6p_c[31:18];
      t2_r[2] <= t2_r[1];
      a_r[3]  <= a_r[2];
      e_r[0]  <= e0_c[30:0];
    end
  end

  // repeated squaring, rounded half up at each step
  for (genvar k = 1; k <= SQ; k++) begin : g_sq
    logic [61:0] p;
    assign p = (e_r[k-1] * e_r[k-1]) + 62'(ONE_Q30 >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k] <= p[60:30];
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic [31:0]   den_r [QW+1];
  logic [31:0]   rem_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [31:0]   den_c;

  assign den_c = ONE_Q30 + {1'b0, e_r[SQ]};

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den_c;
      rem_r[0] <= (ONE_Q30 >> 1) + {18'd0, den_c[31:18]};
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[s-1], den_r[s-1][QW+1-s]};
    assign ge    = trial >= {1'b0, den_r[s-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? 32'(trial - {1'b0, den_r[s-1]}) : trial[31:0];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= {q_r[s-1][QW-2:0], ge};
      end
    end
  end

  // output register
  logic [15:0]   act_c;
  logic [15:0]   act_r;
  logic [PW-1:0] orow_r, ocol_r;
  logic          last_r;

  always_comb begin
    if (meta_r[NSTG-1].neg) begin
      act_c = 16'(17'h10000 - q_r[QW]);
    end else if (q_r[QW][QW-1]) begin
      act_c = 16'hFFFF;
    end else begin
      act_c = q_r[QW][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en && v_r[NSTG-1]) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[NSTG-1]) begin
      act_r  <= act_c;
      orow_r <= meta_r[NSTG-1].orow;
      ocol_r <= meta_r[NSTG-1].ocol;
      last_r <= meta_r[NSTG-1].last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, ocol_r, orow_r, act_r};
  assign out_tlast  = last_r;

endmodule

FILE: rtl/core/conv3sig_checker.sv
// Port-level checker for the conv3ch sigmoid layer core, bound to the top level.
// Depends on conv3ch_sigmoid_layer_core_assert.svh.
`timescale 1ns / 1ps
`include "conv3ch_sigmoid_layer_core_assert.svh"

module conv3sig_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result word holds
  `CONV3SIG_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result word changed")

  // the last position of a frame sits on the diagonal corner
  `CONV3SIG_ASSERT_IMP(a_last_corner, out_tvalid && out_tlast, out_tdata[20:16] == out_tdata[25:21], "frame end off the corner")

  // bias sweep blocks input right after reset
  `CONV3SIG_ASSERT_IMP(a_sweep_blocks, $rose(rst_n), !in_tready, "input taken during bias sweep")

  // padding bits of a result stay zero
  `CONV3SIG_ASSERT_IMP(a_out_pad, out_tvalid, out_tdata[31:26] == 6'd0, "result padding not zero")

endmodule

bind conv3ch_sigmoid_layer_core conv3sig_checker u_conv3sig_checker (.*);

FILE: tb/conv3ch_sigmoid_layer_core_tb.sv
// Self-checking testbench for conv3ch_sigmoid_layer_core: streams loads and pixels,
// predicts each window's activation and compares it with the output stream.
// Depends on conv3sig_pkg and the core RTL.
`timescale 1ns / 1ps

module conv3ch_sigmoid_layer_core_tb;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int LIMIT = 400000;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] p0, p1, p2;
    logic [1:0]         tch;
    logic [4:0]         row, col;
    logic signed [15:0] val;
    bit                 has_exp;
    logic [15:0]        exp_act;
  } word_t;

  typedef struct {
    logic [15:0] act;
    logic [4:0]  row, col;
    logic        last;
  } result_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en = 0;
  logic [5:0]  cfg_wr_data = '0;

  always #2 clk = ~clk;

  conv3ch_sigmoid_layer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // model state
  logic signed [15:0] taps [3][3][3];
  logic signed [15:0] biases [1024];
  logic signed [15:0] lines [3][32][3];
  int    img_size = 32;
  int    prow = 0, pcol = 0;
  result_t act_q[$];
  int    fails = 0;
  int    words_sent = 0;
  bit    calm = 0;
  int    cycles = 0;

  function automatic logic [15:0] sigmoid_act(int s);
    longint unsigned a, t, t2, t3, t4, e, den, q;
    a = (s < 0) ? longint'(-s) : longint'(s);
    t = a << 10;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    t4 = (t3 * t) >> 30;
    e = ONE_Q30 - t + t2 / 2 - t3 / 6 + t4 / 24;
    for (int i = 0; i < 8; i++) e = (e * e + (ONE_Q30 >> 1)) >> 30;
    den = ONE_Q30 + e;
    q = ((64'd1 << 46) + den / 2) / den;
    if (s < 0) return 16'(65536 - q);
    return (q > 65535) ? 16'hFFFF : 16'(q);
  endfunction

  // update the state for one accepted word; queue a result if a window completes
  function automatic void predict_window(word_t w);
    int n, r, c, orow, ocol, slot, s;
    longint acc;
    result_t res;
    if (w.kind == conv3sig_pkg::REQ_TAP) begin
      if (w.tch < 3 && w.row < 3 && w.col < 3) taps[w.tch][w.row][w.col] = w.val;
      return;
    end
    if (w.kind == conv3sig_pkg::REQ_BIAS) begin
      biases[w.row * 32 + w.col] = w.val;
      return;
    end
    if (w.kind != conv3sig_pkg::REQ_PIXEL) return;
    n = img_size < 3 ? 3 : (img_size > 32 ? 32 : img_size);
    r = prow;
    c = pcol;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    lines[r % 3][c][0] = w.p0;
    lines[r % 3][c][1] = w.p1;
    lines[r % 3][c][2] = w.p2;
    if (r >= 2 && c >= 2) begin
      orow = r - 2;
      ocol = c - 2;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        slot = (r + 1 + i) % 3;
        for (int j = 0; j < 3; j++)
          for (int ch = 0; ch < 3; ch++)
            acc += longint'(taps[ch][i][j]) * longint'(lines[slot][ocol + j][ch]);
      end
      acc += longint'(biases[orow * 32 + ocol]) * 4096;
      acc = (acc + 2048) >>> 12;
      s = (acc < -32768) ? -32768 : (acc > 32767 ? 32767 : int'(acc));
      res.act = w.has_exp ? w.exp_act : sigmoid_act(s);
      res.row = 5'(orow);
      res.col = 5'(ocol);
      res.last = (r + 1 == n && c + 1 == n);
      act_q.push_back(res);
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    prow = r;
    pcol = c;
  endfunction

  function automatic word_t mk(logic [1:0] k, int a0, int a1, int a2, int tc, int rw, int cl,
                               int v, bit he = 0, int ea = 0);
    word_t w;
    w.kind = k; w.p0 = 16'(a0); w.p1 = 16'(a1); w.p2 = 16'(a2);
    w.tch = 2'(tc); w.row = 5'(rw); w.col = 5'(cl); w.val = 16'(v);
    w.has_exp = he; w.exp_act = 16'(ea);
    return w;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023)) - 16'sd512;
  endfunction

  task automatic send_word(word_t w);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= w.kind;
    in_tdata  <= {4'h0, w.val, w.col, w.row, w.tch, w.p2, w.p1, w.p0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_window(w);
    words_sent++;
    calm = (words_sent >= 500 && words_sent < 700);
  endtask

  // let the pipeline drain before touching the register
  task automatic drain();
    in_tvalid <= 0;
    while (act_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic set_size(int v);
    drain();
    cfg_wr_en   <= 1;
    cfg_wr_data <= 6'(v);
    @(posedge clk);
    cfg_wr_en <= 0;
    img_size = v;
    prow = 0;
    pcol = 0;
  endtask

  task automatic send_load(int n);
    word_t w;
    w = mk($urandom_range(1, 2) == 1 ? conv3sig_pkg::REQ_TAP : conv3sig_pkg::REQ_BIAS,
           $urandom, $urandom, $urandom, 0, 0, 0, rand_sample());
    w.tch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      w.row = 5'($urandom);
      w.col = 5'($urandom);
    end else if (w.kind == conv3sig_pkg::REQ_TAP) begin
      w.row = 5'($urandom_range(0, 2));
      w.col = 5'($urandom_range(0, 2));
    end else begin
      w.row = 5'($urandom_range(0, n - 1));
      w.col = 5'($urandom_range(0, n - 1));
    end
    send_word(w);
  endtask

  // output side: check on accept, then decide next ready
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (act_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        fails++;
      end else begin
        e = act_q.pop_front();
        if (out_tdata[15:0] !== e.act) begin
          $error("activation: expected %0d got %0d", e.act, out_tdata[15:0]);
          fails++;
        end
        if (out_tdata[20:16] !== e.row) begin
          $error("out_row: expected %0d got %0d", e.row, out_tdata[20:16]);
          fails++;
        end
        if (out_tdata[25:21] !== e.col) begin
          $error("out_col: expected %0d got %0d", e.col, out_tdata[25:21]);
          fails++;
        end
        if (out_tlast !== e.last) begin
          $error("frame_last: expected %0d got %0d", e.last, out_tlast);
          fails++;
        end
      end
    end
    out_tready <= calm || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("conv3ch_sigmoid_layer_core_tb: errors");
      $finish;
    end
  end

  initial begin
    word_t dir_tab[$];
    int sz, n, frames, npix;
    foreach (taps[i, j, k]) taps[i][j][k] = 0;
    foreach (biases[i]) biases[i] = 0;
    foreach (lines[i, j, k]) lines[i][j][k] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // zero taps and biases give sigmoid(0) = one half; written 0 clamps to 3
    for (int i = 0; i < 8; i++)
      dir_tab.push_back(mk(conv3sig_pkg::REQ_PIXEL, 32767, -32768, i, 0, 0, 0, 0));
    dir_tab.push_back(mk(conv3sig_pkg::REQ_PIXEL, 1, 2, 3, 0, 0, 0, 0, 1, 32768));
    dir_tab.push_back(mk(conv3sig_pkg::REQ_TAP, 0, 0, 0, 3, 0, 0, 4096));  // bad channel: drop
    dir_tab.push_back(mk(conv3sig_pkg::REQ_TAP, 0, 0, 0, 0, 3, 0, 4096));  // row out of filter
    dir_tab.push_back(mk(conv3sig_pkg::REQ_TAP, 0, 0, 0, 1, 0, 31, 4096)); // column out
    dir_tab.push_back(mk(REQ_NONE, 5, 5, 5, 0, 0, 0, 100));                // unknown kind
    dir_tab.push_back(mk(conv3sig_pkg::REQ_TAP, 0, 0, 0, 0, 0, 0, 32767));
    dir_tab.push_back(mk(conv3sig_pkg::REQ_TAP, 0, 0, 0, 1, 2, 2, -32768));
    dir_tab.push_back(mk(conv3sig_pkg::REQ_TAP, 0, 0, 0, 2, 1, 1, 4096));
    dir_tab.push_back(mk(conv3sig_pkg::REQ_BIAS, 0, 0, 0, 0, 31, 31, 7));
    for (int i = 0; i < 8; i++)
      dir_tab.push_back(mk(conv3sig_pkg::REQ_PIXEL, 32767, 32767, -32768, 0, 0, 0, 0));
    dir_tab.push_back(mk(conv3sig_pkg::REQ_PIXEL, -32768, -32768, 32767, 0, 0, 0, 0));

    set_size(0);
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    // large bias at the only position: saturate negative
    set_size(2);
    send_word(mk(conv3sig_pkg::REQ_BIAS, 0, 0, 0, 0, 0, 0, -32768));
    for (int i = 0; i < 9; i++) send_word(mk(conv3sig_pkg::REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0));

    for (int ph = 0; words_sent < 1300; ph++) begin
      case (ph)
        0: sz = 63;
        1: sz = 32;
        2: sz = 1;
        default: sz = $urandom_range(0, 12);
      endcase
      set_size(sz);
      n = sz < 3 ? 3 : (sz > 32 ? 32 : sz);
      repeat ($urandom_range(3, 12)) send_load(n);
      frames = (n <= 8) ? $urandom_range(1, 3) : 1;
      npix = (n == 32) ? 3 * 32 + 5 : frames * n * n;
      for (int k = 0; k < npix && words_sent < 1300; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0)
            send_word(mk(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom));
          else
            send_load(n);
        end
        send_word(mk(conv3sig_pkg::REQ_PIXEL, rand_sample(), rand_sample(), rand_sample(),
                     $urandom, $urandom, $urandom, $urandom));
      end
    end

    drain();
    if (fails == 0) begin
      $display("conv3ch_sigmoid_layer_core_tb: clean");
    end else begin
      $display("conv3ch_sigmoid_layer_core_tb: errors");
    end
    $finish;
  end

endmodule
